>>> hdl/ial_pkg.sv
// Shared types, token codes and character-class helpers for the indentation-aware lexer.
// Used by the scanner, the result stage and the top level of the lexer; depends on nothing.
package ial_pkg;

   localparam int POS_W  = 24;
   localparam int COL_W  = 16;
   localparam int KIND_W = 5;
   localparam int CODE_W = 2;

   localparam int DEF_MAX_INDENT_LEVELS = 32;
   localparam int DEF_TAB_STOP          = 8;

   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [COL_W-1:0] COL_MAX = {COL_W{1'b1}};
   localparam logic [7:0]       END_BYTE = 8'hFF;

   // token kinds
   localparam logic [KIND_W-1:0] K_END     = 5'd0;
   localparam logic [KIND_W-1:0] K_NAME    = 5'd1;
   localparam logic [KIND_W-1:0] K_NUMBER  = 5'd2;
   localparam logic [KIND_W-1:0] K_STRING  = 5'd3;
   localparam logic [KIND_W-1:0] K_NEWLINE = 5'd4;
   localparam logic [KIND_W-1:0] K_INDENT  = 5'd5;
   localparam logic [KIND_W-1:0] K_DEDENT  = 5'd6;
   localparam logic [KIND_W-1:0] K_OP      = 5'd27;
   localparam logic [KIND_W-1:0] K_ERROR   = 5'd28;

   // error codes
   localparam logic [CODE_W-1:0] ERR_NONE     = 2'd0;
   localparam logic [CODE_W-1:0] ERR_OVERFLOW = 2'd1;
   localparam logic [CODE_W-1:0] ERR_DEDENT   = 2'd2;
   localparam logic [CODE_W-1:0] ERR_STRING   = 2'd3;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  first;
      logic [POS_W-1:0]  past;
      logic [POS_W-1:0]  line;
      logic [CODE_W-1:0] code;
   } token_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
   endfunction

   // one-byte punctuation to kind
   function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
      logic [KIND_W-1:0] k;
      unique case (c)
         "(": k = 5'd7;
         ")": k = 5'd8;
         "[": k = 5'd9;
         "]": k = 5'd10;
         ":": k = 5'd11;
         ",": k = 5'd12;
         ";": k = 5'd13;
         "+": k = 5'd14;
         "-": k = 5'd15;
         "*": k = 5'd16;
         "/": k = 5'd17;
         "|": k = 5'd18;
         "&": k = 5'd19;
         "<": k = 5'd20;
         ">": k = 5'd21;
         "=": k = 5'd22;
         ".": k = 5'd23;
         "%": k = 5'd24;
         "{": k = 5'd25;
         "}": k = 5'd26;
         default: k = K_OP;
      endcase
      return k;
   endfunction

endpackage

>>> hdl/ial_stack_mem.sv
// Indent-level stack storage: one write port, one registered read port.
// Depends on nothing; entry contents are undefined until written.
module ial_stack_mem #(
   parameter int DEPTH = 32,
   parameter int AW    = 5,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ial_out_stage.sv
// Result side: one pending token plus the output register, sets the last flag.
// Depends on ial_pkg.
module ial_out_stage
   import ial_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                emit_valid,
   input  token_type           emit_tok,
   input  logic                flush,
   output logic                go,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [KIND_W-1:0]   rsp_token_kind,
   output logic [POS_W-1:0]    rsp_token_start,
   output logic [POS_W-1:0]    rsp_token_end,
   output logic [POS_W-1:0]    rsp_line_number,
   output logic [CODE_W-1:0]   rsp_error_code,
   output logic                rsp_last_result
);

   logic      pend_v_ff, pend_v_in;
   token_type pend_ff, pend_in;
   logic      ov_ff, ov_in;
   token_type otok_ff, otok_in;
   logic      olast_ff, olast_in;
   logic      out_free;

   assign out_free = !ov_ff || rsp_ready;
   assign go       = !pend_v_ff || out_free;

   // a new token pushes the pending one out; the step end releases it as last
   always_comb begin
      pend_v_in = pend_v_ff;
      pend_in   = pend_ff;
      ov_in     = ov_ff && !rsp_ready;
      otok_in   = otok_ff;
      olast_in  = olast_ff;
      if (go && emit_valid) begin
         if (pend_v_ff) begin
            ov_in    = 1'b1;
            otok_in  = pend_ff;
            olast_in = 1'b0;
         end
         pend_in   = emit_tok;
         pend_v_in = 1'b1;
      end else if (go && flush && pend_v_ff) begin
         ov_in     = 1'b1;
         otok_in   = pend_ff;
         olast_in  = 1'b1;
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_v_ff <= 1'b0;
         ov_ff     <= 1'b0;
      end else begin
         pend_v_ff <= pend_v_in;
         ov_ff     <= ov_in;
      end
      pend_ff  <= pend_in;
      otok_ff  <= otok_in;
      olast_ff <= olast_in;
   end

   assign rsp_valid       = ov_ff;
   assign rsp_token_kind  = otok_ff.kind;
   assign rsp_token_start = otok_ff.first;
   assign rsp_token_end   = otok_ff.past;
   assign rsp_line_number = otok_ff.line;
   assign rsp_error_code  = otok_ff.code;
   assign rsp_last_result = olast_ff;

endmodule

>>> hdl/ial_scan_ctrl.sv
// Scanner sequencer: scan modes, indentation measure, stack search and token emission.
// Depends on ial_pkg; drives the stack memory and the result stage.
module ial_scan_ctrl
   import ial_pkg::*;
#(
   parameter int MAX_INDENT_LEVELS = DEF_MAX_INDENT_LEVELS,
   parameter int TAB_STOP          = DEF_TAB_STOP,
   parameter int DEPTH_W           = $clog2(MAX_INDENT_LEVELS),
   parameter int TAB_W             = $clog2(TAB_STOP + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ch,
   input  logic               req_end_of_input,
   input  logic               go,
   output logic               emit_valid,
   output token_type          emit_tok,
   output logic               flush,
   output logic               wr_en,
   output logic [DEPTH_W-1:0] wr_addr,
   output logic [COL_W-1:0]   wr_data,
   output logic [DEPTH_W-1:0] rd_addr,
   input  logic [COL_W-1:0]   rd_data
);

   localparam logic [DEPTH_W-1:0] DEPTH_TOP = DEPTH_W'(MAX_INDENT_LEVELS - 1);
   localparam logic [TAB_W-1:0]   REM_TOP   = TAB_W'(TAB_STOP - 1);

   typedef enum logic [2:0] {
      S_IDLE, S_PASS, S_SRCH_RD, S_SRCH_CMP, S_DEDENT, S_FLUSH
   } state_type;

   typedef enum logic [3:0] {
      M_BOL, M_INDENT, M_START, M_COMMENT, M_NAME, M_ZERO, M_HEX, M_OCT,
      M_DEC, M_FRAC, M_EXP, M_EXPDIG, M_STR, M_STRESC, M_CONT, M_CONTCR
   } mode_type;

   state_type           state_ff, state_in;
   mode_type            mode_ff, mode_in;
   logic                halted_ff, halted_in;
   logic [CODE_W-1:0]   hcode_ff, hcode_in;
   logic [DEPTH_W-1:0]  depth_ff, depth_in;
   logic [COL_W-1:0]    top_ff, top_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [TAB_W-1:0]    rem_ff, rem_in;
   logic [POS_W-1:0]    bpos_ff, bpos_in;
   logic [POS_W-1:0]    tbeg_ff, tbeg_in;
   logic [POS_W-1:0]    line_ff, line_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [7:0]          ch_ff, ch_in;
   logic                end_ff, end_in;
   logic [DEPTH_W-1:0]  k_ff, k_in;
   logic [DEPTH_W-1:0]  dcnt_ff, dcnt_in;

   logic [POS_W-1:0]    pos1;
   logic [COL_W:0]      tab_sum;
   logic [COL_W-1:0]    stk_val;
   logic                c_sp, c_tab, c_cr, c_lf, c_bs, c_quote, c_dig, c_name, c_e;
   logic                num_stay;
   mode_type            num_mode;
   logic                halt_v;
   logic [CODE_W-1:0]   halt_c;
   logic [POS_W-1:0]    halt_s;

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      return (v == POS_MAX) ? v : v + POS_W'(1);
   endfunction

   assign req_ready = (state_ff == S_IDLE);
   assign pos1      = sat_inc(pos_ff);
   assign tab_sum   = {1'b0, col_ff} + (COL_W+1)'(TAB_STOP) - (COL_W+1)'(rem_ff);
   assign stk_val   = (k_ff == '0) ? '0 : rd_data;
   assign rd_addr   = k_ff;
   assign wr_addr   = depth_ff + DEPTH_W'(1);
   assign wr_data   = col_ff;

   // byte classes; the end symbol matches none of them
   always_comb begin
      c_sp    = !end_ff && ch_ff == " ";
      c_tab   = !end_ff && ch_ff == 8'h09;
      c_cr    = !end_ff && ch_ff == 8'h0D;
      c_lf    = !end_ff && ch_ff == 8'h0A;
      c_bs    = !end_ff && ch_ff == "\\";
      c_quote = !end_ff && ch_ff == "'";
      c_dig   = !end_ff && is_digit(ch_ff);
      c_name  = !end_ff && (is_letter(ch_ff) || is_digit(ch_ff) || ch_ff == "_");
      c_e     = !end_ff && (ch_ff == "e" || ch_ff == "E");
   end

   // number continuation
   always_comb begin
      num_stay = 1'b0;
      num_mode = mode_ff;
      unique case (mode_ff)
         M_ZERO: begin
            if (!end_ff && ch_ff == ".") begin
               num_mode = M_FRAC;
               num_stay = 1'b1;
            end else if (!end_ff && (ch_ff == "x" || ch_ff == "X")) begin
               num_mode = M_HEX;
               num_stay = 1'b1;
            end else if (!end_ff && ch_ff >= "0" && ch_ff <= "7") begin
               num_mode = M_OCT;
               num_stay = 1'b1;
            end
         end
         M_HEX: num_stay = !end_ff && is_hex(ch_ff);
         M_OCT: num_stay = !end_ff && ch_ff >= "0" && ch_ff <= "7";
         M_DEC, M_FRAC: begin
            if (c_dig) begin
               num_stay = 1'b1;
            end else if (mode_ff == M_DEC && !end_ff && ch_ff == ".") begin
               num_mode = M_FRAC;
               num_stay = 1'b1;
            end else if (c_e) begin
               num_mode = M_EXP;
               num_stay = 1'b1;
            end
         end
         M_EXP: begin
            if (c_dig || (!end_ff && (ch_ff == "+" || ch_ff == "-"))) begin
               num_mode = M_EXPDIG;
               num_stay = 1'b1;
            end
         end
         default: num_stay = c_dig;
      endcase
   end

   // step sequencer
   always_comb begin
      state_in   = state_ff;
      mode_in    = mode_ff;
      halted_in  = halted_ff;
      hcode_in   = hcode_ff;
      depth_in   = depth_ff;
      top_in     = top_ff;
      col_in     = col_ff;
      rem_in     = rem_ff;
      bpos_in    = bpos_ff;
      tbeg_in    = tbeg_ff;
      line_in    = line_ff;
      pos_in     = pos_ff;
      ch_in      = ch_ff;
      end_in     = end_ff;
      k_in       = k_ff;
      dcnt_in    = dcnt_ff;
      emit_valid = 1'b0;
      emit_tok   = '{kind: K_END, first: pos_ff, past: pos_ff, line: line_ff, code: ERR_NONE};
      flush      = 1'b0;
      wr_en      = 1'b0;
      halt_v     = 1'b0;
      halt_c     = ERR_NONE;
      halt_s     = pos_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ch_in  = req_ch;
               end_in = req_end_of_input || req_ch == END_BYTE;
               pos_in = bpos_ff;
               if (!halted_ff && !req_end_of_input) begin
                  bpos_in = sat_inc(bpos_ff);
               end
               state_in = S_PASS;
            end
         end

         S_PASS: begin
            if (go && halted_ff) begin
               emit_valid    = 1'b1;
               emit_tok.kind = (hcode_ff != ERR_NONE) ? K_ERROR : K_END;
               emit_tok.code = hcode_ff;
               state_in      = S_FLUSH;
            end else if (go) begin
               state_in = S_FLUSH;
               unique case (mode_ff)
                  M_BOL: begin
                     line_in  = sat_inc(line_ff);
                     col_in   = '0;
                     rem_in   = '0;
                     mode_in  = M_INDENT;
                     state_in = S_PASS;
                  end
                  M_INDENT: begin
                     if (c_sp) begin
                        if (col_ff != COL_MAX) begin
                           col_in = col_ff + COL_W'(1);
                           rem_in = (rem_ff == REM_TOP) ? '0 : rem_ff + TAB_W'(1);
                        end
                     end else if (c_tab) begin
                        col_in = tab_sum[COL_W] ? COL_MAX : tab_sum[COL_W-1:0];
                        rem_in = '0;
                     end else if (col_ff > top_ff) begin
                        if (depth_ff == DEPTH_TOP) begin
                           halt_v = 1'b1;
                           halt_c = ERR_OVERFLOW;
                        end else begin
                           depth_in      = depth_ff + DEPTH_W'(1);
                           wr_en         = 1'b1;
                           top_in        = col_ff;
                           emit_valid    = 1'b1;
                           emit_tok.kind = K_INDENT;
                           mode_in       = M_START;
                           state_in      = S_PASS;
                        end
                     end else if (col_ff < top_ff) begin
                        k_in     = depth_ff - DEPTH_W'(1);
                        state_in = S_SRCH_RD;
                     end else begin
                        mode_in  = M_START;
                        state_in = S_PASS;
                     end
                  end
                  M_START: begin
                     if (!(c_sp || c_tab || c_cr)) begin
                        tbeg_in = pos_ff;
                        if (end_ff) begin
                           halt_v = 1'b1;
                        end else if (ch_ff == "#") begin
                           mode_in = M_COMMENT;
                        end else if (is_letter(ch_ff) || ch_ff == "_") begin
                           mode_in = M_NAME;
                        end else if (c_lf) begin
                           emit_valid    = 1'b1;
                           emit_tok.kind = K_NEWLINE;
                           mode_in       = M_BOL;
                        end else if (ch_ff == "0") begin
                           mode_in = M_ZERO;
                        end else if (c_dig) begin
                           mode_in = M_DEC;
                        end else if (c_quote) begin
                           mode_in = M_STR;
                        end else if (c_bs) begin
                           mode_in = M_CONT;
                        end else begin
                           emit_valid    = 1'b1;
                           emit_tok.kind = punct_kind(ch_ff);
                           emit_tok.past = pos1;
                        end
                     end
                  end
                  M_COMMENT: begin
                     if (c_lf) begin
                        emit_valid     = 1'b1;
                        emit_tok.kind  = K_NEWLINE;
                        emit_tok.first = tbeg_ff;
                        mode_in        = M_BOL;
                     end else if (end_ff) begin
                        halt_v = 1'b1;
                        halt_s = tbeg_ff;
                     end
                  end
                  M_NAME: begin
                     if (!c_name) begin
                        emit_valid     = 1'b1;
                        emit_tok.kind  = K_NAME;
                        emit_tok.first = tbeg_ff;
                        mode_in        = M_START;
                        state_in       = S_PASS;
                     end
                  end
                  M_ZERO, M_HEX, M_OCT, M_DEC, M_FRAC, M_EXP, M_EXPDIG: begin
                     if (num_stay) begin
                        mode_in = num_mode;
                     end else begin
                        emit_valid     = 1'b1;
                        emit_tok.kind  = K_NUMBER;
                        emit_tok.first = tbeg_ff;
                        mode_in        = M_START;
                        state_in       = S_PASS;
                     end
                  end
                  M_STR: begin
                     if (c_lf || end_ff) begin
                        halt_v = 1'b1;
                        halt_c = ERR_STRING;
                        halt_s = tbeg_ff;
                     end else if (c_bs) begin
                        mode_in = M_STRESC;
                     end else if (c_quote) begin
                        emit_valid     = 1'b1;
                        emit_tok.kind  = K_STRING;
                        emit_tok.first = tbeg_ff;
                        emit_tok.past  = pos1;
                        mode_in        = M_START;
                     end
                  end
                  M_STRESC: begin
                     if (c_lf || end_ff) begin
                        halt_v = 1'b1;
                        halt_c = ERR_STRING;
                        halt_s = tbeg_ff;
                     end else begin
                        mode_in = M_STR;
                     end
                  end
                  M_CONT, M_CONTCR: begin
                     if (c_cr && mode_ff == M_CONT) begin
                        mode_in = M_CONTCR;
                     end else if (c_lf) begin
                        line_in = sat_inc(line_ff);
                        mode_in = M_START;
                     end else begin
                        halt_v = 1'b1;
                        halt_c = ERR_STRING;
                        halt_s = tbeg_ff;
                     end
                  end
                  default: begin
                     mode_in  = M_START;
                     state_in = S_PASS;
                  end
               endcase
            end
         end

         // memory returns the level below on the next cycle
         S_SRCH_RD: begin
            state_in = S_SRCH_CMP;
         end

         S_SRCH_CMP: begin
            if (col_ff < stk_val) begin
               k_in     = k_ff - DEPTH_W'(1);
               state_in = S_SRCH_RD;
            end else if (col_ff == stk_val) begin
               depth_in = k_ff;
               top_in   = stk_val;
               dcnt_in  = depth_ff - k_ff;
               state_in = S_DEDENT;
            end else if (go) begin
               halt_v   = 1'b1;
               halt_c   = ERR_DEDENT;
               state_in = S_FLUSH;
            end
         end

         S_DEDENT: begin
            if (go) begin
               emit_valid    = 1'b1;
               emit_tok.kind = K_DEDENT;
               dcnt_in       = dcnt_ff - DEPTH_W'(1);
               if (dcnt_ff == DEPTH_W'(1)) begin
                  mode_in  = M_START;
                  state_in = S_PASS;
               end
            end
         end

         S_FLUSH: begin
            if (go) begin
               flush    = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // halting token: end marker or sticky error
      if (halt_v) begin
         emit_valid     = 1'b1;
         emit_tok.kind  = (halt_c != ERR_NONE) ? K_ERROR : K_END;
         emit_tok.first = halt_s;
         emit_tok.past  = pos_ff;
         emit_tok.code  = halt_c;
         halted_in      = 1'b1;
         hcode_in       = halt_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         mode_ff   <= M_BOL;
         halted_ff <= 1'b0;
         hcode_ff  <= ERR_NONE;
         depth_ff  <= '0;
         top_ff    <= '0;
         col_ff    <= '0;
         rem_ff    <= '0;
         bpos_ff   <= '0;
         tbeg_ff   <= '0;
         line_ff   <= '0;
         dcnt_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         mode_ff   <= mode_in;
         halted_ff <= halted_in;
         hcode_ff  <= hcode_in;
         depth_ff  <= depth_in;
         top_ff    <= top_in;
         col_ff    <= col_in;
         rem_ff    <= rem_in;
         bpos_ff   <= bpos_in;
         tbeg_ff   <= tbeg_in;
         line_ff   <= line_in;
         dcnt_ff   <= dcnt_in;
      end
      pos_ff <= pos_in;
      ch_ff  <= ch_in;
      end_ff <= end_in;
      k_ff   <= k_in;
   end

   // stack depth never passes the last level
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_TOP)
      else $error("indent depth beyond last level");

   // once halted, the block stays halted
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halted flag cleared");

   // a dedent run always has at least one level to pop
   a_dedent_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEDENT |-> dcnt_ff != '0)
      else $error("empty dedent run");

   // an accepted byte always starts a scan pass
   a_accept_pass: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == S_PASS)
      else $error("accepted byte not scanned");

endmodule

>>> hdl/indent_aware_source_lexer_core.sv
// Each byte gets a scan pass, with a rescan at line start, at the end of indentation
// and at the end of a name or number; a dedent searches the stack one level at a time
// (read state, then compare state) and emits its DEDENT tokens one by one. One byte is in
// flight at a time; the sequencer takes a new byte only when idle and stalls on rsp_ready.
// Reset clears all control state; the indent stack memory is not cleared, level zero is
// implied as column 0 and higher levels are always written before they are read.
// Top level of the lexer; depends on ial_pkg, ial_scan_ctrl, ial_stack_mem, ial_out_stage.
module indent_aware_source_lexer_core
   import ial_pkg::*;
#(
   parameter int MAX_INDENT_LEVELS = DEF_MAX_INDENT_LEVELS,
   parameter int TAB_STOP          = DEF_TAB_STOP
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_ch,
   input  logic              req_end_of_input,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [KIND_W-1:0] rsp_token_kind,
   output logic [POS_W-1:0]  rsp_token_start,
   output logic [POS_W-1:0]  rsp_token_end,
   output logic [POS_W-1:0]  rsp_line_number,
   output logic [CODE_W-1:0] rsp_error_code,
   output logic              rsp_last_result
);

   localparam int DEPTH_W = $clog2(MAX_INDENT_LEVELS);
   localparam int TAB_W   = $clog2(TAB_STOP + 1);

   logic               go;
   logic               emit_valid;
   token_type          emit_tok;
   logic               flush;
   logic               wr_en;
   logic [DEPTH_W-1:0] wr_addr;
   logic [COL_W-1:0]   wr_data;
   logic [DEPTH_W-1:0] rd_addr;
   logic [COL_W-1:0]   rd_data;

   ial_scan_ctrl #(
      .MAX_INDENT_LEVELS (MAX_INDENT_LEVELS),
      .TAB_STOP          (TAB_STOP),
      .DEPTH_W           (DEPTH_W),
      .TAB_W             (TAB_W)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_ch           (req_ch),
      .req_end_of_input (req_end_of_input),
      .go               (go),
      .emit_valid       (emit_valid),
      .emit_tok         (emit_tok),
      .flush            (flush),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data)
   );

   ial_stack_mem #(
      .DEPTH (MAX_INDENT_LEVELS),
      .AW    (DEPTH_W),
      .DW    (COL_W)
   ) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ial_out_stage u_out (
      .clock           (clock),
      .reset           (reset),
      .emit_valid      (emit_valid),
      .emit_tok        (emit_tok),
      .flush           (flush),
      .go              (go),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_token_kind  (rsp_token_kind),
      .rsp_token_start (rsp_token_start),
      .rsp_token_end   (rsp_token_end),
      .rsp_line_number (rsp_line_number),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_result (rsp_last_result)
   );

endmodule
